// ===== hw/rtl/cstl_pkg.sv =====
package cstl_pkg;

   typedef struct packed {
      logic       cmd;
      logic [7:0] source_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [4:0]  reserved_code;
      logic [23:0] start_position;
      logic [15:0] token_length;
      logic [30:0] token_value;
      logic [1:0]  error_code;
      logic [23:0] error_line;
      logic        last_of_run;
   } rsp_type;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_WORD, MODE_NUMBER, MODE_OPPEND, MODE_LINECMT,
      MODE_BLOCK, MODE_BLOCKSTAR, MODE_STRING, MODE_STRESC, MODE_HALT
   } mode_type;

   localparam logic [2:0] KIND_RESERVED = 3'd0;
   localparam logic [2:0] KIND_IDENT    = 3'd1;
   localparam logic [2:0] KIND_NUMBER   = 3'd2;
   localparam logic [2:0] KIND_STRING   = 3'd3;
   localparam logic [2:0] KIND_STRCHAR  = 3'd4;
   localparam logic [2:0] KIND_END      = 3'd5;
   localparam logic [2:0] KIND_ERROR    = 3'd6;

   localparam logic [1:0] ERR_BAD_CHAR  = 2'd0;
   localparam logic [1:0] ERR_COMMENT   = 2'd1;
   localparam logic [1:0] ERR_STRING    = 2'd2;
   localparam logic [1:0] ERR_TOO_LONG  = 2'd3;

   localparam logic [4:0] CODE_EQ   = 5'd8;
   localparam logic [4:0] CODE_NE   = 5'd9;
   localparam logic [4:0] CODE_LE   = 5'd10;
   localparam logic [4:0] CODE_GE   = 5'd11;
   localparam logic [4:0] CODE_OP1  = 5'd12;

   localparam logic [15:0] LEN_MAX = 16'hFFFF;
   localparam logic [30:0] VAL_MAX = 31'h7FFF_FFFF;

   function automatic logic [4:0] op1_index(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd31;
      unique case (c)
         "+": r = 5'd0;
         "-": r = 5'd1;
         "*": r = 5'd2;
         "/": r = 5'd3;
         "(": r = 5'd4;
         ")": r = 5'd5;
         "<": r = 5'd6;
         ">": r = 5'd7;
         ";": r = 5'd8;
         "=": r = 5'd9;
         "{": r = 5'd10;
         "}": r = 5'd11;
         ",": r = 5'd12;
         "&": r = 5'd13;
         "[": r = 5'd14;
         "]": r = 5'd15;
         default: r = 5'd31;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] escape_of(input logic [7:0] c);
      logic [7:0] r;
      unique case (c)
         "a": r = 8'd7;
         "b": r = 8'd8;
         "t": r = 8'd9;
         "n": r = 8'd10;
         "v": r = 8'd11;
         "f": r = 8'd12;
         "r": r = 8'd13;
         "e": r = 8'd27;
         "0": r = 8'd0;
         default: r = c;
      endcase
      return r;
   endfunction

   // keyword code, or 8 for none
   function automatic logic [3:0] keyword_of(input logic [47:0] w, input logic [15:0] len);
      logic [3:0] r;
      r = 4'd8;
      if (len == 16'd6 && w == "return") r = 4'd0;
      if (len == 16'd2 && w[15:0] == "if") r = 4'd1;
      if (len == 16'd4 && w[31:0] == "else") r = 4'd2;
      if (len == 16'd5 && w[39:0] == "while") r = 4'd3;
      if (len == 16'd3 && w[23:0] == "for") r = 4'd4;
      if (len == 16'd3 && w[23:0] == "int") r = 4'd5;
      if (len == 16'd4 && w[31:0] == "char") r = 4'd6;
      if (len == 16'd6 && w == "sizeof") r = 4'd7;
      return r;
   endfunction

endpackage

// ===== hw/rtl/c_subset_token_lexer.sv =====
// c_subset_token_lexer: streaming lexer for a small C subset
//
// req channel: one beat per source byte (cmd 0) or end of input (cmd 1).
// rsp channel: token beats; one input beat gives zero, one or two result
// beats, the last one flagged by last_of_run.
// an accepted byte is lexed in the same cycle it is taken; its results go to
// a two-entry output queue, so the first result is registered into it at the
// accepting edge. a byte is taken in every cycle while the queue has room for
// two results, so the throughput is one byte per cycle; a two-result beat
// drains at one result per cycle.
// when the receiver stalls the queue holds, and req_stall rises while the
// queue holds two results, or holds one that the receiver is stalling.
// reset (synchronous, active high) returns the lexer to idle, position 0,
// line 1, and empties the queue. after an error beat all further input
// beats are consumed without results until reset.
// end of input flushes a pending token, emits the end beat and restarts the
// lexer for a new source; an error in the flush halts it with no end beat.
module c_subset_token_lexer #(
   parameter int MAX_STRING_CHARS = 1024,
   parameter int POSITION_BITS    = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  cstl_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output cstl_pkg::rsp_type  rsp_data
);
   import cstl_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam logic [10:0] STR_LIMIT = 11'(MAX_STRING_CHARS);

   // lexer state
   mode_type                 mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] line_ff, line_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [15:0]              len_ff, len_in;
   logic [30:0]              acc_ff, acc_in;
   logic [47:0]              win_ff, win_in;
   logic [7:0]               pend_ff, pend_in;
   logic [10:0]              scount_ff, scount_in;

   // output queue, entry 0 is the head
   rsp_type     q_ff [2];
   rsp_type     q_in [2];
   logic [1:0]  qn_ff, qn_in;

   rsp_type     r [2];
   logic [1:0]  rn;
   logic        take, pop;

   // take only when the queue is empty once this cycle's pop is done
   assign req_stall = (qn_ff == 2'd2) || (qn_ff == 2'd1 && rsp_stall);
   assign take      = req_valid && !req_stall;
   assign rsp_valid = (qn_ff != 2'd0);
   assign rsp_data  = q_ff[0];
   assign pop       = rsp_valid && !rsp_stall;

   function automatic rsp_type mk(input logic [2:0] k, input logic [4:0] code,
                                  input logic [POSITION_BITS-1:0] st,
                                  input logic [15:0] ln, input logic [30:0] v,
                                  input logic [1:0] ec,
                                  input logic [POSITION_BITS-1:0] el);
      rsp_type o;
      o.kind           = k;
      o.reserved_code  = code;
      o.start_position = 24'(st);
      o.token_length   = ln;
      o.token_value    = v;
      o.error_code     = ec;
      o.error_line     = 24'(el);
      o.last_of_run    = 1'b0;
      return o;
   endfunction

   logic [7:0]  c;
   logic        is_alpha, is_digit, is_space;
   logic [3:0]  kw;
   logic [4:0]  op_i, pend_i;
   logic [34:0] acc_mul;
   logic [15:0] len_p1;

   always_comb begin
      c        = req_data.source_byte;
      is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      is_digit = (c >= "0" && c <= "9");
      is_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
      kw       = keyword_of(win_ff, len_ff);
      op_i     = op1_index(c);
      pend_i   = op1_index(pend_ff);
      acc_mul  = {4'd0, acc_ff} * 35'd10 + 35'(c - "0");
      len_p1   = (len_ff == LEN_MAX) ? len_ff : len_ff + 16'd1;
   end

   // one step of the lexer
   always_comb begin
      logic do_idle;
      logic err;
      rsp_type e0, e1;
      do_idle   = 1'b0;
      err       = 1'b0;
      e0        = '0;
      e1        = '0;
      rn        = 2'd0;
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      line_in   = line_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      acc_in    = acc_ff;
      win_in    = win_ff;
      pend_in   = pend_ff;
      scount_in = scount_ff;
      r[0]      = '0;
      r[1]      = '0;
      if (take && mode_ff != MODE_HALT) begin
         if (req_data.cmd) begin
            // end of input: flush, then end beat unless the flush is an error
            priority case (mode_ff)
               MODE_WORD: begin
                  r[0] = (kw != 4'd8) ?
                     mk(KIND_RESERVED, {1'b0, kw}, start_ff, len_ff, '0, '0, '0) :
                     mk(KIND_IDENT, '0, start_ff, len_ff, '0, '0, '0);
                  rn = 2'd1;
               end
               MODE_NUMBER: begin
                  r[0] = mk(KIND_NUMBER, '0, start_ff, len_ff, acc_ff, '0, '0);
                  rn = 2'd1;
               end
               MODE_OPPEND: begin
                  if (pend_i == 5'd31) begin
                     r[0] = mk(KIND_ERROR, '0, start_ff, '0, '0, ERR_BAD_CHAR, line_ff);
                     err = 1'b1;
                  end else begin
                     r[0] = mk(KIND_RESERVED, CODE_OP1 + pend_i, start_ff, 16'd1, '0,
                               '0, '0);
                  end
                  rn = 2'd1;
               end
               MODE_BLOCK, MODE_BLOCKSTAR: begin
                  r[0] = mk(KIND_ERROR, '0, pos_ff, '0, '0, ERR_COMMENT, line_ff);
                  rn = 2'd1;
                  err = 1'b1;
               end
               MODE_STRING, MODE_STRESC: begin
                  r[0] = mk(KIND_ERROR, '0, pos_ff, '0, '0,
                            (mode_ff == MODE_STRING && scount_ff >= STR_LIMIT) ?
                            ERR_TOO_LONG : ERR_STRING, line_ff);
                  rn = 2'd1;
                  err = 1'b1;
               end
               default: ;
            endcase
            if (err) begin
               mode_in = MODE_HALT;
            end else begin
               r[rn[0]] = mk(KIND_END, '0, pos_ff, '0, '0, '0, '0);
               rn = rn + 2'd1;
               mode_in = MODE_IDLE;
               pos_in = '0;
               line_in = POSITION_BITS'(1);
               start_in = '0;
               len_in = '0;
               acc_in = '0;
               win_in = '0;
               pend_in = '0;
               scount_in = '0;
            end
         end else begin
            priority case (mode_ff)
               MODE_IDLE: do_idle = 1'b1;
               MODE_WORD: begin
                  if (is_alpha || is_digit) begin
                     len_in = len_p1;
                     win_in = {win_ff[39:0], c};
                  end else begin
                     e0 = (kw != 4'd8) ?
                        mk(KIND_RESERVED, {1'b0, kw}, start_ff, len_ff, '0, '0, '0) :
                        mk(KIND_IDENT, '0, start_ff, len_ff, '0, '0, '0);
                     rn = 2'd1;
                     mode_in = MODE_IDLE;
                     do_idle = 1'b1;
                  end
               end
               MODE_NUMBER: begin
                  if (is_digit) begin
                     len_in = len_p1;
                     acc_in = (acc_mul > {4'd0, VAL_MAX}) ? VAL_MAX : acc_mul[30:0];
                  end else begin
                     e0 = mk(KIND_NUMBER, '0, start_ff, len_ff, acc_ff, '0, '0);
                     rn = 2'd1;
                     mode_in = MODE_IDLE;
                     do_idle = 1'b1;
                  end
               end
               MODE_OPPEND: begin
                  if (pend_ff == "/" && c == "/") begin
                     mode_in = MODE_LINECMT;
                  end else if (pend_ff == "/" && c == "*") begin
                     mode_in = MODE_BLOCK;
                  end else if (pend_ff != "/" && c == "=") begin
                     e0 = mk(KIND_RESERVED, (pend_ff == "=") ? CODE_EQ :
                             (pend_ff == "!") ? CODE_NE : (pend_ff == "<") ? CODE_LE :
                             CODE_GE, start_ff, 16'd2, '0, '0, '0);
                     rn = 2'd1;
                     mode_in = MODE_IDLE;
                  end else if (pend_i == 5'd31) begin
                     e0 = mk(KIND_ERROR, '0, start_ff, '0, '0, ERR_BAD_CHAR, line_ff);
                     rn = 2'd1;
                     mode_in = MODE_HALT;
                  end else begin
                     e0 = mk(KIND_RESERVED, CODE_OP1 + pend_i, start_ff, 16'd1, '0,
                             '0, '0);
                     rn = 2'd1;
                     mode_in = MODE_IDLE;
                     do_idle = 1'b1;
                  end
               end
               MODE_LINECMT: if (c == 8'h0A) mode_in = MODE_IDLE;
               MODE_BLOCK: if (c == "*") mode_in = MODE_BLOCKSTAR;
               MODE_BLOCKSTAR: begin
                  if (c == "/") mode_in = MODE_IDLE;
                  else if (c != "*") mode_in = MODE_BLOCK;
               end
               MODE_STRING: begin
                  if (scount_ff >= STR_LIMIT) begin
                     e0 = mk(KIND_ERROR, '0, pos_ff, '0, '0, ERR_TOO_LONG, line_ff);
                     rn = 2'd1;
                     mode_in = MODE_HALT;
                  end else begin
                     len_in = len_p1;
                     if (c == "\"") begin
                        e0 = mk(KIND_STRING, '0, start_ff, len_p1, 31'(scount_ff),
                                '0, '0);
                        rn = 2'd1;
                        mode_in = MODE_IDLE;
                     end else if (c == "\\") begin
                        mode_in = MODE_STRESC;
                     end else begin
                        e0 = mk(KIND_STRCHAR, '0, pos_ff, 16'd1, 31'(c), '0, '0);
                        rn = 2'd1;
                        scount_in = scount_ff + 11'd1;
                     end
                  end
               end
               MODE_STRESC: begin
                  len_in = len_p1;
                  e0 = mk(KIND_STRCHAR, '0, pos_ff - POSITION_BITS'(1), 16'd2,
                          31'(escape_of(c)), '0, '0);
                  rn = 2'd1;
                  scount_in = scount_ff + 11'd1;
                  mode_in = MODE_STRING;
               end
               default: ;
            endcase
            // fresh byte in idle context
            if (do_idle && !is_space) begin
               start_in = pos_ff;
               if (is_alpha) begin
                  mode_in = MODE_WORD;
                  len_in = 16'd1;
                  win_in = {40'd0, c};
               end else if (is_digit) begin
                  mode_in = MODE_NUMBER;
                  len_in = 16'd1;
                  acc_in = 31'(c - "0");
               end else if (c == "\"") begin
                  mode_in = MODE_STRING;
                  len_in = 16'd1;
                  scount_in = '0;
               end else if (c == "/" || c == "=" || c == "<" || c == ">" || c == "!") begin
                  mode_in = MODE_OPPEND;
                  pend_in = c;
               end else if (op_i != 5'd31) begin
                  e1 = mk(KIND_RESERVED, CODE_OP1 + op_i, pos_ff, 16'd1, '0, '0, '0);
                  rn = rn + 2'd1;
               end else begin
                  e1 = mk(KIND_ERROR, '0, pos_ff, '0, '0, ERR_BAD_CHAR, line_ff);
                  rn = rn + 2'd1;
                  mode_in = MODE_HALT;
               end
            end
            if (rn == 2'd2) begin
               r[0] = e0;
               r[1] = e1;
            end else if (e0.kind != 3'd0 || e0.reserved_code != 5'd0 ||
                         e0.token_length != 16'd0) begin
               r[0] = e0;
            end else begin
               r[0] = e1;
            end
            if (c == 8'h0A && line_ff != POS_MAX) line_in = line_ff + POSITION_BITS'(1);
            pos_in = pos_ff + POSITION_BITS'(1);
         end
         if (rn != 2'd0) r[rn[1]].last_of_run = 1'b1;
      end
   end

   // output queue
   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      qn_in   = qn_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         qn_in   = qn_ff - 2'd1;
      end
      if (rn != 2'd0) begin
         q_in[0] = r[0];
         q_in[1] = r[1];
         qn_in   = rn;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         line_ff   <= POSITION_BITS'(1);
         start_ff  <= '0;
         len_ff    <= '0;
         acc_ff    <= '0;
         win_ff    <= '0;
         pend_ff   <= '0;
         scount_ff <= '0;
         qn_ff     <= '0;
      end else begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         line_ff   <= line_in;
         start_ff  <= start_in;
         len_ff    <= len_in;
         acc_ff    <= acc_in;
         win_ff    <= win_in;
         pend_ff   <= pend_in;
         scount_ff <= scount_in;
         qn_ff     <= qn_in;
      end
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

   // results only arrive into a queue that is empty after this cycle's pop
   assert property (@(posedge clock) disable iff (reset)
      rn != 2'd0 |-> qn_ff == 2'd0 || (qn_ff == 2'd1 && pop))
      else $error("result while queue busy");
   // a halted lexer never produces results
   assert property (@(posedge clock) disable iff (reset) mode_ff == MODE_HALT |-> rn == 2'd0)
      else $error("result while halted");
   // an error beat in the first result slot halts the lexer
   assert property (@(posedge clock) disable iff (reset)
      rn != 2'd0 && r[0].kind == KIND_ERROR |=> mode_ff == MODE_HALT)
      else $error("error without halt");
   // string count never exceeds its limit
   assert property (@(posedge clock) disable iff (reset) scount_ff <= STR_LIMIT)
      else $error("string count overflow");

endmodule
